@@ src/vebt_pkg.sv @@
`default_nettype none

package vebt_pkg;

  // Chunk geometry and id width
  localparam int CHUNK_EDGE = 16;
  localparam int ID_BITS    = 8;

  // Fixed port widths
  localparam int COORD_W = 4;
  localparam int BLOCK_W = 8;

  // Internal coordinate width: wide enough for the port field and the chunk edge
  localparam int EDGE_W     = $clog2(CHUNK_EDGE);
  localparam int CRD_W      = (EDGE_W > COORD_W) ? EDGE_W : COORD_W;
  localparam int CELL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
  localparam int ADDR_BITS  = $clog2(CELL_COUNT);
  localparam int WIDE_W     = ID_BITS + BLOCK_W;

  typedef logic [CRD_W-1:0]     crd_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [2:0]           face_t;

  // Face codes, in report order; SELF means no step
  localparam face_t FACE_XN   = 3'd0;
  localparam face_t FACE_XP   = 3'd1;
  localparam face_t FACE_YN   = 3'd2;
  localparam face_t FACE_YP   = 3'd3;
  localparam face_t FACE_ZN   = 3'd4;
  localparam face_t FACE_ZP   = 3'd5;
  localparam face_t FACE_SELF = 3'd6;
  localparam int    FACE_COUNT = 6;

  localparam id_t ID_EMPTY = '0;
  localparam id_t ID_RESET = id_t'(1);

  // Result of one pass through the face stepper
  typedef struct packed {
    crd_t  x;
    crd_t  y;
    crd_t  z;
    logic  in_range;
    addr_t addr;
  } probe_t;

  function automatic id_t to_id(input logic [BLOCK_W-1:0] b);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(b);
    return w[ID_BITS-1:0];
  endfunction

  function automatic logic [BLOCK_W-1:0] to_byte(input id_t id);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(id);
    return w[BLOCK_W-1:0];
  endfunction

  function automatic addr_t cell_addr(input crd_t x, input crd_t y, input crd_t z);
    return addr_t'(z) * addr_t'(CHUNK_EDGE * CHUNK_EDGE)
         + addr_t'(y) * addr_t'(CHUNK_EDGE) + addr_t'(x);
  endfunction

  function automatic logic on_border(input crd_t x, input crd_t y, input crd_t z);
    return (x == '0) || (x == crd_t'(CHUNK_EDGE - 1)) ||
           (y == '0) || (y == crd_t'(CHUNK_EDGE - 1)) ||
           (z == '0) || (z == crd_t'(CHUNK_EDGE - 1));
  endfunction

  function automatic logic in_chunk(input crd_t x, input crd_t y, input crd_t z);
    return ({1'b0, x} < (CRD_W+1)'(CHUNK_EDGE)) &&
           ({1'b0, y} < (CRD_W+1)'(CHUNK_EDGE)) &&
           ({1'b0, z} < (CRD_W+1)'(CHUNK_EDGE));
  endfunction

endpackage

`default_nettype wire

@@ src/vebt_ram.sv @@
`default_nettype none

// Simple dual-port RAM, one write port and one registered read port
module vebt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/vebt_face.sv @@
`default_nettype none

// Face stepper: moves a cell one step along a face, flags bounds, forms the address
module vebt_face (
  input  wire vebt_pkg::crd_t  base_x_i,
  input  wire vebt_pkg::crd_t  base_y_i,
  input  wire vebt_pkg::crd_t  base_z_i,
  input  wire vebt_pkg::face_t face_i,
  output vebt_pkg::probe_t     probe_o
);

  import vebt_pkg::*;

  logic [CRD_W:0] ex, ey, ez;

  always_comb begin
    ex = {1'b0, base_x_i};
    ey = {1'b0, base_y_i};
    ez = {1'b0, base_z_i};
    unique case (face_i)
      FACE_XN: ex = ex - (CRD_W+1)'(1);
      FACE_XP: ex = ex + (CRD_W+1)'(1);
      FACE_YN: ey = ey - (CRD_W+1)'(1);
      FACE_YP: ey = ey + (CRD_W+1)'(1);
      FACE_ZN: ez = ez - (CRD_W+1)'(1);
      FACE_ZP: ez = ez + (CRD_W+1)'(1);
      default: ;
    endcase
  end

  // Underflow wraps to all ones, which always fails the bound check
  assign probe_o.x        = ex[CRD_W-1:0];
  assign probe_o.y        = ey[CRD_W-1:0];
  assign probe_o.z        = ez[CRD_W-1:0];
  assign probe_o.in_range = (ex < (CRD_W+1)'(CHUNK_EDGE)) &&
                            (ey < (CRD_W+1)'(CHUNK_EDGE)) &&
                            (ez < (CRD_W+1)'(CHUNK_EDGE));
  assign probe_o.addr     = cell_addr(ex[CRD_W-1:0], ey[CRD_W-1:0], ez[CRD_W-1:0]);

endmodule

`default_nettype wire

@@ src/voxel_exposed_block_tracker_top.sv @@
`default_nettype none

// Exposed-block tracker for one 16x16x16 voxel chunk held in a single RAM with one
// write and one registered read port. After reset the block fills every cell with
// id 1 and holds in_ready_o low meanwhile. A transaction is handled one at a time by
// a sequencer that walks the reported cells and their face neighbors through one
// shared face stepper and the RAM read port. After the accept, each reported cell is
// stepped to and fetched; a filled interior cell then starts the neighbor fetch and
// probes its neighbors in order (up to six, stopping at the first empty one); last,
// the result is handed over. A query or a retype yields one result, a write of the
// id already stored yields none, and a write that fills or empties a cell up to seven.
// Results leave through an output register, so the next result is formed while the
// previous one waits for out_ready_i.
module voxel_exposed_block_tracker_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       mode_i,
  input  wire logic [3:0] cell_x_i,
  input  wire logic [3:0] cell_y_i,
  input  wire logic [3:0] cell_z_i,
  input  wire logic [7:0] new_block_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [3:0]      out_x_o,
  output logic [3:0]      out_y_o,
  output logic [3:0]      out_z_o,
  output logic [7:0]      out_block_o,
  output logic            drawn_o,
  output logic            last_o
);

  import vebt_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SUBJ  = 3'd2;
  localparam logic [2:0] S_SREAD = 3'd3;
  localparam logic [2:0] S_PROBE = 3'd4;
  localparam logic [2:0] S_PREAD = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  addr_t      clr_cnt_q, clr_cnt_d;
  crd_t       cx_q, cy_q, cz_q, cx_d, cy_d, cz_d;
  crd_t       sx_q, sy_q, sz_q, sx_d, sy_d, sz_d;
  addr_t      saddr_q, saddr_d;
  id_t        nb_q, nb_d;
  id_t        sid_q, sid_d;
  logic       wr_pend_q, wr_pend_d;
  logic       single_q, single_d;
  logic       drawn_q, drawn_d;
  face_t      fs_q, fs_d;
  face_t      fp_q, fp_d;
  logic [FACE_COUNT-1:0] mask_q, mask_d;

  logic       out_valid_q, out_valid_d;
  crd_t       ox_q, oy_q, oz_q, ox_d, oy_d, oz_d;
  id_t        oid_q, oid_d;
  logic       odrawn_q, odrawn_d, olast_q, olast_d;

  crd_t       base_x, base_y, base_z, in_x, in_y, in_z;
  face_t      face_sel;
  probe_t     probe;
  logic       ram_we;
  addr_t      ram_waddr;
  id_t        ram_wdata, rd_id, eval_id;
  logic       accept, out_take, out_free, last_now;
  logic [FACE_COUNT-1:0] above;
  face_t      next_face;

  assign in_x = crd_t'(cell_x_i);
  assign in_y = crd_t'(cell_y_i);
  assign in_z = crd_t'(cell_z_i);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_take   = out_valid_q && out_ready_i;
  assign out_free   = !out_valid_q || out_ready_i;

  // Shared stepper input: subject step from the center, probe step from the subject
  always_comb begin
    if (state_q == S_SUBJ) begin
      base_x   = cx_q;
      base_y   = cy_q;
      base_z   = cz_q;
      face_sel = fs_q;
    end else begin
      base_x   = sx_q;
      base_y   = sy_q;
      base_z   = sz_q;
      face_sel = (state_q == S_PREAD) ? fp_q + face_t'(1) : fp_q;
    end
  end

  vebt_face u_face (
    .base_x_i (base_x),
    .base_y_i (base_y),
    .base_z_i (base_z),
    .face_i   (face_sel),
    .probe_o  (probe)
  );

  vebt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (CELL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (probe.addr),
    .rdata_o (rd_id)
  );

  // Neighbors still to report after the current subject
  always_comb begin
    next_face = FACE_SELF;
    for (int i = FACE_COUNT - 1; i >= 0; i--) begin
      above[i] = mask_q[i] && ((fs_q == FACE_SELF) || (face_t'(i) > fs_q));
      if (above[i]) begin
        next_face = face_t'(i);
      end
    end
  end

  assign last_now = single_q || (above == '0);
  assign eval_id  = wr_pend_q ? nb_q : rd_id;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sz_d        = sz_q;
    saddr_d     = saddr_q;
    nb_d        = nb_q;
    sid_d       = sid_q;
    wr_pend_d   = wr_pend_q;
    single_d    = single_q;
    drawn_d     = drawn_q;
    fs_d        = fs_q;
    fp_d        = fp_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !out_take;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;
    oid_d       = oid_q;
    odrawn_d    = odrawn_q;
    olast_d     = olast_q;
    ram_we      = 1'b0;
    ram_waddr   = saddr_q;
    ram_wdata   = nb_q;

    unique case (state_q)
      // Fill the store with id 1 after reset
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = ID_RESET;
        clr_cnt_d = clr_cnt_q + addr_t'(1);
        if (clr_cnt_q == addr_t'(CELL_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          cx_d      = in_x;
          cy_d      = in_y;
          cz_d      = in_z;
          sx_d      = in_x;
          sy_d      = in_y;
          sz_d      = in_z;
          nb_d      = to_id(new_block_i);
          wr_pend_d = !mode_i;
          single_d  = mode_i;
          fs_d      = FACE_SELF;
          mask_d    = {in_z != crd_t'(CHUNK_EDGE - 1), in_z != '0,
                       in_y != crd_t'(CHUNK_EDGE - 1), in_y != '0,
                       in_x != crd_t'(CHUNK_EDGE - 1), in_x != '0};
          if (in_chunk(in_x, in_y, in_z)) begin
            state_d = S_SUBJ;
          end else if (mode_i) begin
            // Query outside the chunk: id 0, not drawn
            sid_d   = ID_EMPTY;
            drawn_d = 1'b0;
            state_d = S_EMIT;
          end
        end
      end

      // Step to the subject cell and fetch it
      S_SUBJ: begin
        sx_d    = probe.x;
        sy_d    = probe.y;
        sz_d    = probe.z;
        saddr_d = probe.addr;
        state_d = S_SREAD;
      end

      S_SREAD: begin
        sid_d = eval_id;
        if (wr_pend_q) begin
          wr_pend_d = 1'b0;
        end
        if (wr_pend_q && (rd_id == nb_q)) begin
          state_d = S_IDLE;
        end else if (wr_pend_q && ((rd_id == ID_EMPTY) == (nb_q == ID_EMPTY))) begin
          // Retype between two filled ids
          ram_we   = 1'b1;
          single_d = 1'b1;
          drawn_d  = 1'b1;
          state_d  = S_EMIT;
        end else begin
          ram_we = wr_pend_q;
          if (eval_id == ID_EMPTY) begin
            drawn_d = 1'b0;
            state_d = S_EMIT;
          end else if (on_border(sx_q, sy_q, sz_q)) begin
            drawn_d = 1'b1;
            state_d = S_EMIT;
          end else begin
            fp_d    = FACE_XN;
            state_d = S_PROBE;
          end
        end
      end

      // First neighbor fetch of an interior subject
      S_PROBE: begin
        state_d = S_PREAD;
      end

      // One neighbor per cycle; stop at the first empty one
      S_PREAD: begin
        if (rd_id == ID_EMPTY) begin
          drawn_d = 1'b1;
          state_d = S_EMIT;
        end else if (fp_q == FACE_ZP) begin
          drawn_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          fp_d = fp_q + face_t'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ox_d        = sx_q;
          oy_d        = sy_q;
          oz_d        = sz_q;
          oid_d       = sid_q;
          odrawn_d    = drawn_q;
          olast_d     = last_now;
          if (last_now) begin
            state_d = S_IDLE;
          end else begin
            fs_d    = next_face;
            state_d = S_SUBJ;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      wr_pend_q   <= 1'b0;
      single_q    <= 1'b0;
      fs_q        <= FACE_SELF;
      fp_q        <= FACE_XN;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      wr_pend_q   <= wr_pend_d;
      single_q    <= single_d;
      fs_q        <= fs_d;
      fp_q        <= fp_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sz_q     <= sz_d;
    saddr_q  <= saddr_d;
    nb_q     <= nb_d;
    sid_q    <= sid_d;
    drawn_q  <= drawn_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oz_q     <= oz_d;
    oid_q    <= oid_d;
    odrawn_q <= odrawn_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q[COORD_W-1:0];
  assign out_y_o     = oy_q[COORD_W-1:0];
  assign out_z_o     = oz_q[COORD_W-1:0];
  assign out_block_o = to_byte(oid_q);
  assign drawn_o     = odrawn_q;
  assign last_o      = olast_q;

endmodule

`default_nettype wire
